// File: hdl/fwht_pkg.sv
// ----------------------------------------------------------------------------
// fwht_pkg
// shared types and constants of the fast walsh-hadamard transform block
// ----------------------------------------------------------------------------
`default_nettype none

package fwht_pkg;

    localparam int COEFF_BITS = 23;
    localparam int INDEX_BITS = 6;
    localparam int LOG_BITS   = 3;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_BF_RD,
        ST_BF_WR0,
        ST_BF_WR1,
        ST_OUT_RD,
        ST_OUT_SHOW
    } state_t;

    typedef enum logic [1:0] {
        WR_SAMPLE,
        WR_SUM,
        WR_DIFF
    } wr_sel_t;

    typedef struct packed {
        logic                  wr_en;
        wr_sel_t               wr_sel;
        logic [INDEX_BITS-1:0] wr_addr;
        logic                  rd_en;
        logic [INDEX_BITS-1:0] rd_addr_a;
        logic [INDEX_BITS-1:0] rd_addr_b;
    } dp_cmd_t;

endpackage

`default_nettype wire

// File: hdl/fwht_datapath.sv
// ----------------------------------------------------------------------------
// fwht_datapath
// work buffer memory with two registered read ports, butterfly adder and
// write data selection
// ----------------------------------------------------------------------------
`default_nettype none

module fwht_datapath
    import fwht_pkg::*;
#(
    parameter int ADDR_W      = 6,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                          aclk,
    input  wire dp_cmd_t                       cmd,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    output logic signed [COEFF_BITS-1:0]       coeff
);

    localparam int DEPTH = 1 << ADDR_W;
    localparam int EXT_W = (SAMPLE_BITS > COEFF_BITS) ? SAMPLE_BITS : COEFF_BITS;

    logic [COEFF_BITS-1:0] mem [DEPTH];
    logic [COEFF_BITS-1:0] rd_a_reg;
    logic [COEFF_BITS-1:0] rd_b_reg;

    logic signed [EXT_W-1:0] sample_ext;
    logic [COEFF_BITS-1:0]   sum;
    logic [COEFF_BITS-1:0]   diff;
    logic [COEFF_BITS-1:0]   wr_data;

    assign sample_ext = EXT_W'(sample);
    assign sum        = rd_a_reg + rd_b_reg;
    assign diff       = rd_a_reg - rd_b_reg;

    always_comb begin
        case (cmd.wr_sel)
            WR_SAMPLE: wr_data = sample_ext[COEFF_BITS-1:0];
            WR_SUM:    wr_data = sum;
            WR_DIFF:   wr_data = diff;
            default:   wr_data = sample_ext[COEFF_BITS-1:0];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[cmd.wr_addr[ADDR_W-1:0]] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_a_reg <= mem[cmd.rd_addr_a[ADDR_W-1:0]];
            rd_b_reg <= mem[cmd.rd_addr_b[ADDR_W-1:0]];
        end
    end

    assign coeff = rd_a_reg;

endmodule

`default_nettype wire

// File: hdl/fwht_ctrl.sv
// ----------------------------------------------------------------------------
// fwht_ctrl
// sequencer for load, butterfly passes and coefficient output, holds the
// length register
// ----------------------------------------------------------------------------
`default_nettype none

module fwht_ctrl
    import fwht_pkg::*;
#(
    parameter int MAX_LOG_ORDER = 6
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [LOG_BITS-1:0]   cfg_log_order,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [INDEX_BITS-1:0]      m_coeff_index,
    output logic                       m_last,
    output dp_cmd_t                    cmd
);

    localparam int ADDR_W = MAX_LOG_ORDER;

    state_t              state_reg,     state_next;
    logic [LOG_BITS-1:0] log_order_reg, log_order_next;
    logic [ADDR_W-1:0]   load_cnt_reg,  load_cnt_next;
    logic [LOG_BITS-1:0] pass_reg,      pass_next;
    logic [ADDR_W-1:0]   bf_reg,        bf_next;
    logic [ADDR_W-1:0]   out_idx_reg,   out_idx_next;

    logic [LOG_BITS-1:0] eff_log;
    logic [ADDR_W-1:0]   len_mask;
    logic [ADDR_W-1:0]   half_mask;
    logic [ADDR_W-1:0]   low_mask;
    logic [ADDR_W-1:0]   idx0;
    logic [ADDR_W-1:0]   idx1;

    // clamp the length register into the supported range
    always_comb begin
        if (log_order_reg == '0) begin
            eff_log = LOG_BITS'(1);
        end else if (log_order_reg > LOG_BITS'(MAX_LOG_ORDER)) begin
            eff_log = LOG_BITS'(MAX_LOG_ORDER);
        end else begin
            eff_log = log_order_reg;
        end
    end

    assign len_mask  = ~({ADDR_W{1'b1}} << eff_log);
    assign half_mask = len_mask >> 1;

    // butterfly pair: insert a zero bit at the pass position
    assign low_mask = ~({ADDR_W{1'b1}} << pass_reg);
    assign idx0     = ((bf_reg & ~low_mask) << 1) | (bf_reg & low_mask);
    assign idx1     = idx0 | (ADDR_W'(1) << pass_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            log_order_reg <= LOG_BITS'(1);
            load_cnt_reg  <= '0;
            pass_reg      <= '0;
            bf_reg        <= '0;
            out_idx_reg   <= '0;
        end else begin
            state_reg     <= state_next;
            log_order_reg <= log_order_next;
            load_cnt_reg  <= load_cnt_next;
            pass_reg      <= pass_next;
            bf_reg        <= bf_next;
            out_idx_reg   <= out_idx_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        log_order_next = log_order_reg;
        load_cnt_next  = load_cnt_reg;
        pass_next      = pass_reg;
        bf_next        = bf_reg;
        out_idx_next   = out_idx_reg;

        cfg_ready = 1'b0;
        s_ready   = 1'b0;
        m_valid   = 1'b0;

        cmd.wr_en     = 1'b0;
        cmd.wr_sel    = WR_SAMPLE;
        cmd.wr_addr   = INDEX_BITS'(load_cnt_reg);
        cmd.rd_en     = 1'b0;
        cmd.rd_addr_a = INDEX_BITS'(idx0);
        cmd.rd_addr_b = INDEX_BITS'(idx1);

        case (state_reg)
            ST_LOAD: begin
                cfg_ready = 1'b1;
                s_ready   = !cfg_valid;
                if (cfg_valid) begin
                    log_order_next = cfg_log_order;
                    load_cnt_next  = '0;
                end else if (s_valid) begin
                    cmd.wr_en = 1'b1;
                    if (load_cnt_reg == len_mask) begin
                        load_cnt_next = '0;
                        pass_next     = '0;
                        bf_next       = '0;
                        state_next    = ST_BF_RD;
                    end else begin
                        load_cnt_next = load_cnt_reg + ADDR_W'(1);
                    end
                end
            end
            ST_BF_RD: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_BF_WR0;
            end
            ST_BF_WR0: begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = WR_SUM;
                cmd.wr_addr = INDEX_BITS'(idx0);
                state_next  = ST_BF_WR1;
            end
            ST_BF_WR1: begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = WR_DIFF;
                cmd.wr_addr = INDEX_BITS'(idx1);
                if (bf_reg == half_mask) begin
                    bf_next = '0;
                    if (pass_reg == eff_log - LOG_BITS'(1)) begin
                        out_idx_next = '0;
                        state_next   = ST_OUT_RD;
                    end else begin
                        pass_next  = pass_reg + LOG_BITS'(1);
                        state_next = ST_BF_RD;
                    end
                end else begin
                    bf_next    = bf_reg + ADDR_W'(1);
                    state_next = ST_BF_RD;
                end
            end
            ST_OUT_RD: begin
                cmd.rd_en     = 1'b1;
                cmd.rd_addr_a = INDEX_BITS'(out_idx_reg);
                state_next    = ST_OUT_SHOW;
            end
            ST_OUT_SHOW: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (out_idx_reg == len_mask) begin
                        out_idx_next = '0;
                        state_next   = ST_LOAD;
                    end else begin
                        out_idx_next = out_idx_reg + ADDR_W'(1);
                        state_next   = ST_OUT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    assign m_coeff_index = INDEX_BITS'(out_idx_reg);
    assign m_last        = (out_idx_reg == len_mask);

endmodule

`default_nettype wire

// File: hdl/fast_walsh_hadamard_transform.sv
// sequence: a vector of n = 2^log_order samples loads in n accepted transfers,
// then log_order passes of n/2 butterflies run, each a read, a sum write and
// a difference write (one memory write port), then each coefficient is read
// into the registered read port and held until taken; loading waits meanwhile
// reset: synchronous active-low aresetn clears the sequencer, sets log_order to 1
// and empties the partial vector; the work buffer is not cleared
// ----------------------------------------------------------------------------
// fast_walsh_hadamard_transform
// unnormalized integer fast walsh-hadamard transform over up to 64 samples
// ----------------------------------------------------------------------------
`default_nettype none

module fast_walsh_hadamard_transform
    import fwht_pkg::*;
#(
    parameter int MAX_LOG_ORDER = 6,
    parameter int SAMPLE_BITS   = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [LOG_BITS-1:0]           cfg_log_order,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] s_sample,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [COEFF_BITS-1:0]       m_coeff,
    output logic [INDEX_BITS-1:0]              m_coeff_index,
    output logic                               m_last
);

    dp_cmd_t cmd;

    fwht_ctrl #(
        .MAX_LOG_ORDER (MAX_LOG_ORDER)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_log_order (cfg_log_order),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_coeff_index (m_coeff_index),
        .m_last        (m_last),
        .cmd           (cmd)
    );

    fwht_datapath #(
        .ADDR_W      (MAX_LOG_ORDER),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .aclk   (aclk),
        .cmd    (cmd),
        .sample (s_sample),
        .coeff  (m_coeff)
    );

endmodule

`default_nettype wire

// File: hdl/fwht_checker.sv
// ----------------------------------------------------------------------------
// fwht_checker
// port-level checks of the transform block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module fwht_checker
    import fwht_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_ready,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire logic [COEFF_BITS-1:0] m_coeff,
    input wire logic [INDEX_BITS-1:0] m_coeff_index,
    input wire logic                  m_last
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_coeff) && $stable(m_coeff_index))
        else $error("stalled result changed");

    // no loading while coefficients are out
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready during output");

    // final transfer returns to loading
    a_last_load: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last |=> !m_valid && s_ready)
        else $error("no return to load after last coefficient");

    // coefficients come in index order
    a_index_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> ##1
            (m_valid && m_coeff_index == $past(m_coeff_index, 2) + INDEX_BITS'(1)))
        else $error("coefficient index out of order");

endmodule

bind fast_walsh_hadamard_transform fwht_checker u_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_coeff       (m_coeff),
    .m_coeff_index (m_coeff_index),
    .m_last        (m_last)
);

`default_nettype wire

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the fast walsh-hadamard transform block. samples are
// streamed in with bursty valid, coefficients are drained under varying
// backpressure, and every coefficient is compared against a behavioral
// butterfly predictor kept in a scoreboard. the length register is swept over
// all of its codes, including the out-of-range ones and a change mid-vector
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import fwht_pkg::*;

    localparam int MAX_LOG     = 6;
    localparam int SAMPLE_BITS = 16;
    localparam int MAX_LEN     = 1 << MAX_LOG;

    typedef struct {
        logic signed [COEFF_BITS-1:0] coeff;
        logic [INDEX_BITS-1:0]        idx;
        logic                         last;
    } coeff_t;

    class coeff_scoreboard;
        coeff_t              expected_coeffs[$];
        logic [LOG_BITS-1:0] log_order;
        int unsigned         loaded;
        int                  work[MAX_LEN];
        int                  errors;
        int                  checked;
        int                  vectors;

        function new();
            log_order = 3'd1;
            loaded    = 0;
            errors    = 0;
            checked   = 0;
            vectors   = 0;
        endfunction

        function int unsigned vector_length();
            int unsigned lg;
            lg = 32'(log_order);
            if (lg < 1) lg = 1;
            if (lg > MAX_LOG) lg = MAX_LOG;
            return 1 << lg;
        endfunction

        function int pending();
            return expected_coeffs.size();
        endfunction

        function void set_log_order(logic [LOG_BITS-1:0] value);
            log_order = value;
            loaded    = 0;
        endfunction

        // stores one sample and, on the last one, runs the butterfly passes
        function void note_sample(logic signed [SAMPLE_BITS-1:0] sample);
            int unsigned len;
            int unsigned sep;
            int unsigned i0;
            int unsigned i1;
            int unsigned a;
            int unsigned k;
            int          u;
            int          w;
            coeff_t      c;
            len = vector_length();
            if (loaded >= len) loaded = 0;
            work[loaded] = int'(sample);
            loaded++;
            if (loaded < len) return;
            loaded = 0;
            for (sep = 1; sep < len; sep = sep << 1) begin
                for (a = 0; a < len / 2; a++) begin
                    i0 = 2 * a - (a % sep);
                    i1 = i0 + sep;
                    u = work[i0];
                    w = work[i1];
                    work[i0] = u + w;
                    work[i1] = u - w;
                end
            end
            for (k = 0; k < len; k++) begin
                c.coeff = work[k][COEFF_BITS-1:0];
                c.idx   = k[INDEX_BITS-1:0];
                c.last  = (k == len - 1);
                expected_coeffs.push_back(c);
            end
            vectors++;
        endfunction

        function void check_coeff(logic signed [COEFF_BITS-1:0] coeff,
                                  logic [INDEX_BITS-1:0] idx, logic last);
            coeff_t exp_c;
            if (expected_coeffs.size() == 0) begin
                $display("%0t unexpected coefficient transfer: coeff %0d index %0d last %0b",
                         $time, coeff, idx, last);
                errors++;
                return;
            end
            exp_c = expected_coeffs.pop_front();
            checked++;
            if (coeff !== exp_c.coeff) begin
                $display("%0t coeff mismatch at index %0d: expected %0d, actual %0d",
                         $time, exp_c.idx, exp_c.coeff, coeff);
                errors++;
            end
            if (idx !== exp_c.idx) begin
                $display("%0t coeff_index mismatch: expected %0d, actual %0d",
                         $time, exp_c.idx, idx);
                errors++;
            end
            if (last !== exp_c.last) begin
                $display("%0t last mismatch at index %0d: expected %0b, actual %0b",
                         $time, exp_c.idx, exp_c.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [LOG_BITS-1:0]           cfg_log_order;
    logic                          s_valid;
    logic                          s_ready;
    logic signed [SAMPLE_BITS-1:0] s_sample;
    logic                          m_valid;
    logic                          m_ready;
    logic signed [COEFF_BITS-1:0]  m_coeff;
    logic [INDEX_BITS-1:0]         m_coeff_index;
    logic                          m_last;

    coeff_scoreboard sb;
    int              burst_left;
    int              rx_hold_request;
    int              samples_sent;
    int              cfg_writes;

    fast_walsh_hadamard_transform #(
        .MAX_LOG_ORDER(MAX_LOG),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_log_order(cfg_log_order),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample     (s_sample),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_coeff      (m_coeff),
        .m_coeff_index(m_coeff_index),
        .m_last       (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

    // receiver: checks each transfer, stalls on changing patterns
    initial begin
        int cyc;
        int mode;
        int hold_left;
        cyc       = 0;
        mode      = 0;
        hold_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready)
                sb.check_coeff(m_coeff, m_coeff_index, m_last);
            if (rx_hold_request > 0) begin
                hold_left       = rx_hold_request;
                rx_hold_request = 0;
            end
            cyc++;
            if (cyc % 50 == 0) mode = $urandom_range(0, 3);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= (cyc % 3 != 0);
                endcase
            end
        end
    end

    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid  <= 1'b1;
        s_sample <= value;
        do @(posedge aclk); while (!s_ready);
        sb.note_sample(value);
        samples_sent++;
    endtask

    task automatic wait_drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_log_order(input logic [LOG_BITS-1:0] value);
        wait_drain();
        // let a lone sample write settle before the register changes
        repeat (16) @(posedge aclk);
        cfg_valid     <= 1'b1;
        cfg_log_order <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_log_order(value);
        cfg_writes++;
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return '0;
            3: return '1;
            default: return SAMPLE_BITS'($urandom_range(0, 65535));
        endcase
    endfunction

    // style 0 random, 1 all max, 2 all min, 3 alternating extremes
    task automatic send_vector(input int unsigned len, input int style);
        int unsigned k;
        for (k = 0; k < len; k++) begin
            case (style)
                1: send_sample(16'sh7fff);
                2: send_sample(16'sh8000);
                3: send_sample(k[0] ? 16'sh8000 : 16'sh7fff);
                default: send_sample(pick_sample());
            endcase
        end
    endtask

    initial begin
        logic [LOG_BITS-1:0] forced[8];
        logic [LOG_BITS-1:0] lg_val;
        int                  phase;
        int                  random_items;
        int                  nvec;
        int                  style;
        int unsigned         len;
        sb              = new();
        burst_left      = 0;
        rx_hold_request = 0;
        samples_sent    = 0;
        cfg_writes      = 0;
        forced          = '{3'd3, 3'd7, 3'd0, 3'd5, 3'd1, 3'd4, 3'd6, 3'd2};
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_sample      <= '0;
        cfg_valid     <= 1'b0;
        cfg_log_order <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // length after reset is two
        send_sample(16'sh7fff);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample(16'sh8000);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        // zero length code behaves as two, odd sample left pending
        write_log_order(3'd0);
        send_sample(-16'sd1);
        send_sample(16'sd0);
        send_sample(16'sd1);
        write_log_order(3'd2);
        send_vector(4, 1);
        send_vector(4, 2);
        // change length with a partial vector held
        send_sample(16'sd1);
        send_sample(16'sd2);
        send_sample(-16'sd3);

        phase        = 0;
        random_items = 0;
        while (phase < 8 || random_items < 230) begin
            if (phase < 8)
                lg_val = forced[phase];
            else if ($urandom_range(0, 3) != 0)
                lg_val = LOG_BITS'($urandom_range(0, 4));
            else
                lg_val = LOG_BITS'($urandom_range(0, 7));
            write_log_order(lg_val);
            len  = sb.vector_length();
            nvec = (len >= 32) ? 1 : $urandom_range(1, 4);
            if (phase == 5) begin
                nvec            = 3;
                rx_hold_request = 600;
            end
            for (int v = 0; v < nvec; v++) begin
                if (phase == 1) style = 2;
                else if (phase == 6) style = 1;
                else if ($urandom_range(0, 5) == 0) style = $urandom_range(1, 3);
                else style = 0;
                send_vector(len, style);
                random_items += len;
                // sender pauses for the full result set
                if (phase == 0) wait_drain();
            end
            if ($urandom_range(0, 3) == 0)
                send_vector($urandom_range(1, len - 1), 0);
            phase++;
        end

        wait_drain();
        repeat (300) @(posedge aclk);
        $display("run covered %0d samples in %0d vectors, %0d coefficients checked,",
                 samples_sent, sb.vectors, sb.checked);
        $display("with %0d length register writes including out-of-range codes",
                 cfg_writes);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
hdl/fwht_pkg.sv
hdl/fwht_datapath.sv
hdl/fwht_ctrl.sv
hdl/fast_walsh_hadamard_transform.sv
hdl/fwht_checker.sv
test/tb_top.sv
